[hw/rtl/rrdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rrdf_pkg;
  localparam int unsigned EntriesDefault = 16;
  localparam logic [39:0] LifetimeReset  = 40'd300000000;
  localparam logic [47:0] TimeMax        = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] orig_prefix_hi;
    logic [63:0] orig_prefix_lo;
    logic [7:0]  orig_prefix_length;
    logic [63:0] target_prefix_hi;
    logic [63:0] target_prefix_lo;
    logic [63:0] router_addr_hi;
    logic [63:0] router_addr_lo;
    logic [7:0]  metric_kind;
    logic [15:0] orig_sequence;
    logic [7:0]  route_metric;
    logic [47:0] now_us;
  } req_t;

  typedef struct packed {
    logic verdict;
    logic table_full;
  } res_t;

  // one stored entry, expiry included
  typedef struct packed {
    logic [63:0] orig_hi;
    logic [63:0] orig_lo;
    logic [7:0]  orig_len;
    logic [63:0] target_hi;
    logic [63:0] target_lo;
    logic [63:0] router_hi;
    logic [63:0] router_lo;
    logic [7:0]  metric_kind;
    logic [15:0] sequence_num;
    logic [7:0]  metric;
    logic [47:0] expiry;
  } entry_t;
endpackage
`default_nettype wire

[hw/rtl/rrdf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rrdf_req_if;
  import rrdf_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rrdf_res_if;
  import rrdf_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/rrdf_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrdf_mem import rrdf_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire entry_t          wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output      entry_t          rdata_o
);
  entry_t mem_q [Entries];

  // write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/route_request_duplicate_filter_top.sv]
// The result follows the first pass through the entries when that pass decides, and the
// second pass otherwise.
// Requests: one at a time; the next transfer is taken the cycle after the result
// transfers; each request scans the entry memory (one read per cycle) once or twice, and
// a stalled result stalls the input.
// Reset: valid bits clear, lifetime register loads 300000000, memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module route_request_duplicate_filter_top import rrdf_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [39:0] cfg_wdata_i,
  rrdf_req_if.sink         req,
  rrdf_res_if.source       res
);
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [CntW-1:0] Last = CntW'(Entries - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StFin  = 3'd2;
  localparam logic [2:0] StScn2 = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]      st_q;
  logic [39:0]     life_q;
  req_t            req_q;
  logic [Entries-1:0] valid_q;
  logic [CntW-1:0] rcnt_q;     // read address counter
  logic [CntW-1:0] ccnt_q;     // index of data now on rdata
  logic            rvld_q;     // rdata belongs to current scan
  logic            found_q;
  logic [IdxW-1:0] hit_q;
  entry_t          hit_e_q;
  logic            red_q;
  logic            full_q;
  res_t            res_q;
  logic            rv_q;

  entry_t          rdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;

  rrdf_mem #(.Entries(Entries)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // expiry with saturation
  logic [48:0] exp_sum;
  logic [47:0] new_exp;
  assign exp_sum = {1'b0, req_q.now_us} + {9'd0, life_q};
  assign new_exp = exp_sum[48] ? TimeMax : exp_sum[47:0];

  logic [IdxW-1:0] cidx;
  logic flow_eq, rtr_eq, live;
  assign cidx    = ccnt_q[IdxW-1:0];
  assign flow_eq = rdata.orig_hi == req_q.orig_prefix_hi &&
                   rdata.orig_lo == req_q.orig_prefix_lo &&
                   rdata.orig_len == req_q.orig_prefix_length &&
                   rdata.target_hi == req_q.target_prefix_hi &&
                   rdata.target_lo == req_q.target_prefix_lo &&
                   rdata.metric_kind == req_q.metric_kind;
  assign rtr_eq  = rdata.router_hi == req_q.router_addr_hi &&
                   rdata.router_lo == req_q.router_addr_lo;
  // valid and not stale
  assign live    = valid_q[cidx] && (req_q.now_us < rdata.expiry);

  logic [15:0] d;
  assign d = hit_e_q.sequence_num - req_q.orig_sequence;

  logic [Entries-1:0] fv;  // valid bits after this item's expiry
  logic [IdxW-1:0] free_idx;
  logic any_free;
  assign fv = valid_q;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!fv[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  assign raddr    = rcnt_q[IdxW-1:0];
  assign req.ready = (st_q == StIdle) && !rv_q;
  assign res.valid = rv_q;
  assign res.payload = res_q;

  // memory writes happen in StFin only
  always_comb begin
    we    = 1'b0;
    waddr = hit_q;
    wdata = hit_e_q;
    if (st_q == StFin) begin
      if (!found_q) begin
        we    = any_free;
        waddr = free_idx;
        wdata.orig_hi      = req_q.orig_prefix_hi;
        wdata.orig_lo      = req_q.orig_prefix_lo;
        wdata.orig_len     = req_q.orig_prefix_length;
        wdata.target_hi    = req_q.target_prefix_hi;
        wdata.target_lo    = req_q.target_prefix_lo;
        wdata.router_hi    = req_q.router_addr_hi;
        wdata.router_lo    = req_q.router_addr_lo;
        wdata.metric_kind  = req_q.metric_kind;
        wdata.sequence_num = req_q.orig_sequence;
        wdata.metric       = req_q.route_metric;
        wdata.expiry       = new_exp;
      end else begin
        we = 1'b1;
        wdata.expiry = new_exp;
        if (!((d != 16'd0 && !d[15]) ||
              (d == 16'd0 && hit_e_q.metric <= req_q.route_metric))) begin
          wdata.sequence_num = req_q.orig_sequence;
          wdata.metric       = req_q.route_metric;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.payload;
    if (st_q == StScan && rvld_q && !found_q && live && flow_eq && rtr_eq) hit_e_q <= rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      life_q  <= LifetimeReset;
      valid_q <= '0;
      rcnt_q  <= '0;
      ccnt_q  <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      hit_q   <= '0;
      red_q   <= 1'b0;
      full_q  <= 1'b0;
      res_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (cfg_we_i) life_q <= cfg_wdata_i;
      if (res.valid && res.ready) rv_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (req.valid && !rv_q) begin
            st_q    <= StScan;
            rcnt_q  <= '0;
            rvld_q  <= 1'b0;
            found_q <= 1'b0;
            red_q   <= 1'b0;
            full_q  <= 1'b0;
          end
        end
        // first pass: expire and search for exact match
        StScan: begin
          ccnt_q <= rcnt_q;
          rvld_q <= (rcnt_q <= Last);
          if (rcnt_q <= Last) rcnt_q <= rcnt_q + 1'b1;
          if (rvld_q) begin
            if (valid_q[cidx] && !(req_q.now_us < rdata.expiry)) valid_q[cidx] <= 1'b0;
            if (!found_q && live && flow_eq && rtr_eq) begin
              found_q <= 1'b1;
              hit_q   <= cidx;
            end
            if (ccnt_q == Last) begin
              st_q   <= StFin;
              rvld_q <= 1'b0;
            end
          end
        end
        // insert or refresh, decide on second pass
        StFin: begin
          rcnt_q <= '0;
          rvld_q <= 1'b0;
          if (!found_q) begin
            if (any_free) valid_q[free_idx] <= 1'b1;
            full_q <= !any_free;
            st_q   <= StOut;
          end else if ((d != 16'd0 && !d[15]) ||
                       (d == 16'd0 && hit_e_q.metric <= req_q.route_metric)) begin
            red_q <= 1'b1;
            st_q  <= StOut;
          end else begin
            st_q <= StScn2;
          end
        end
        // second pass: compatible entry with metric no worse
        StScn2: begin
          ccnt_q <= rcnt_q;
          rvld_q <= (rcnt_q <= Last);
          if (rcnt_q <= Last) rcnt_q <= rcnt_q + 1'b1;
          if (rvld_q) begin
            if (cidx != hit_q && valid_q[cidx] && flow_eq &&
                rdata.metric <= req_q.route_metric) red_q <= 1'b1;
            if (ccnt_q == Last) st_q <= StOut;
          end
        end
        StOut: begin
          res_q <= '{verdict: red_q, table_full: full_q};
          rv_q  <= 1'b1;
          st_q  <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // accept only when no result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |-> !rv_q) else $error("accept with pending result");
  // a full table never reports redundant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> !(res_q.verdict && res_q.table_full)) else $error("full and redundant");
  // memory writes only in the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> st_q == StFin) else $error("stray memory write");
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import rrdf_pkg::*;

  localparam int Slots = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [39:0] cfg_wdata_i = '0;

  rrdf_req_if req ();
  rrdf_res_if res ();

  route_request_duplicate_filter_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .res(res.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // filter state kept by the testbench
  logic [39:0] lifetime;
  logic        tbl_valid [Slots];
  entry_t      tbl [Slots];
  res_t        verdicts_due [$];
  int          errors = 0;
  logic [47:0] clock_us = '0;
  bit          gaps_on = 1'b1;
  int          hold_cycles = 0;

  // flows used to build colliding records
  req_t flows [8];

  function automatic bit flow_eq(entry_t e, req_t r);
    return e.orig_hi == r.orig_prefix_hi && e.orig_lo == r.orig_prefix_lo &&
           e.orig_len == r.orig_prefix_length && e.target_hi == r.target_prefix_hi &&
           e.target_lo == r.target_prefix_lo && e.metric_kind == r.metric_kind;
  endfunction

  function automatic logic [47:0] expiry_at(logic [47:0] now);
    logic [48:0] t;
    t = {1'b0, now} + {9'b0, lifetime};
    return t[48] ? TimeMax : t[47:0];
  endfunction

  // apply one request to the table and return the verdict
  function automatic res_t filter_request(req_t r);
    res_t o;
    int hit;
    logic [15:0] d;
    o = '0;
    hit = -1;
    for (int k = 0; k < Slots; k++)
      if (tbl_valid[k] && r.now_us >= tbl[k].expiry) tbl_valid[k] = 1'b0;
    for (int k = 0; k < Slots; k++)
      if (hit < 0 && tbl_valid[k] && flow_eq(tbl[k], r) &&
          tbl[k].router_hi == r.router_addr_hi && tbl[k].router_lo == r.router_addr_lo)
        hit = k;
    if (hit < 0) begin
      for (int k = 0; k < Slots; k++)
        if (hit < 0 && !tbl_valid[k]) hit = k;
      if (hit < 0) begin
        o.table_full = 1'b1;
        return o;
      end
      tbl_valid[hit] = 1'b1;
      tbl[hit] = '{r.orig_prefix_hi, r.orig_prefix_lo, r.orig_prefix_length,
                   r.target_prefix_hi, r.target_prefix_lo, r.router_addr_hi,
                   r.router_addr_lo, r.metric_kind, r.orig_sequence, r.route_metric,
                   expiry_at(r.now_us)};
      return o;
    end
    tbl[hit].expiry = expiry_at(r.now_us);
    d = tbl[hit].sequence_num - r.orig_sequence;
    if (d != 0 && d < 16'h8000) begin
      o.verdict = 1'b1;
      return o;
    end
    if (d == 0 && tbl[hit].metric <= r.route_metric) begin
      o.verdict = 1'b1;
      return o;
    end
    tbl[hit].sequence_num = r.orig_sequence;
    tbl[hit].metric = r.route_metric;
    for (int k = 0; k < Slots; k++)
      if (k != hit && tbl_valid[k] && flow_eq(tbl[k], r) && tbl[k].metric <= r.route_metric)
        o.verdict = 1'b1;
    return o;
  endfunction

  // send one request, predict on transfer; valid drops only for an idle gap or a drain
  task automatic send_request(req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req.payload <= r;
    req.valid <= 1'b1;
    do @(posedge clk_i); while (!req.ready);
    verdicts_due.push_back(filter_request(r));
    @(negedge clk_i);
  endtask

  function automatic req_t random_record();
    req_t r;
    logic [479:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    return r;
  endfunction

  // record on a known flow, with a fresh time
  function automatic req_t flow_record(logic [47:0] step_max);
    req_t r;
    r = flows[$urandom_range(0, 7)];
    if ($urandom_range(0, 3) == 0) r.router_addr_lo = {$urandom, $urandom};
    r.orig_sequence = r.orig_sequence + 16'($urandom_range(0, 6)) - 16'd3;
    if ($urandom_range(0, 15) == 0) r.orig_sequence = 16'($urandom);
    r.route_metric = 8'($urandom_range(0, 12));
    if ($urandom_range(0, 15) == 0) r.route_metric = 8'($urandom);
    clock_us = clock_us + 48'($urandom_range(0, int'(step_max)));
    r.now_us = clock_us;
    return r;
  endfunction

  task automatic drain_results();
    req.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_lifetime(logic [39:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lifetime = v;
  endtask

  // extremes, wrap of sequence numbers, equal sequence, better record, full table
  task automatic test_directed();
    req_t r;
    r = flows[0];
    r.now_us = 48'd10;
    send_request(r);
    r.route_metric = 8'd5;
    send_request(r);                       // equal sequence
    r.route_metric = 8'd0;
    send_request(r);                       // equal sequence, better metric
    r.orig_sequence = r.orig_sequence - 16'd1;
    send_request(r);                       // stored newer
    r.orig_sequence = r.orig_sequence + 16'h8001;
    send_request(r);                       // received newer across wrap
    r.router_addr_lo = ~r.router_addr_lo;
    r.route_metric = 8'd255;
    send_request(r);                       // second router, new entry
    r.orig_sequence = r.orig_sequence + 16'd1;
    send_request(r);                       // better, but another router has it cheaper
    r = '1;
    r.now_us = 48'd20;
    send_request(r);
    r = '0;
    r.now_us = 48'd20;
    r.orig_prefix_length = 8'd200;
    send_request(r);
    for (int i = 0; i < 14; i++) begin
      r = random_record();
      r.now_us = 48'd30;
      send_request(r);                     // fills, then overflows
    end
    write_lifetime(40'd0);
    r.now_us = 48'd40;
    send_request(r);                       // stored entries are still live, table still full
    send_request(r);                       // same request, table still full
    write_lifetime(40'hFF_FFFF_FFFF);
    r.now_us = TimeMax - 48'd5;
    send_request(r);                       // saturating expiry
    send_request(r);
    clock_us = TimeMax - 48'd5;
  endtask

  task automatic test_random(int n, logic [39:0] life, logic [47:0] step_max);
    req_t r;
    write_lifetime(life);
    // one in ten records is fully random, the rest reuse known flows
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = random_record();
        clock_us = clock_us + 48'($urandom_range(0, int'(step_max)));
        r.now_us = clock_us;
      end else r = flow_record(step_max);
      send_request(r);
    end
  endtask

  task automatic test_backpressure();
    req_t r;
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) begin
      r = flow_record(48'd5);
      send_request(r);
    end
  endtask

  // ready driver
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        res.ready <= 1'b1;
      end else res.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (res.valid && res.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with none expected: %b", $realtime, res.payload);
        errors++;
      end else begin
        res_t want;
        want = verdicts_due.pop_front();
        if (res.payload.verdict !== want.verdict) begin
          $display("%0t: verdict expected %b actual %b", $realtime, want.verdict,
                   res.payload.verdict);
          errors++;
        end
        if (res.payload.table_full !== want.table_full) begin
          $display("%0t: table_full expected %b actual %b", $realtime, want.table_full,
                   res.payload.table_full);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    lifetime = LifetimeReset;
    for (int k = 0; k < Slots; k++) begin
      tbl_valid[k] = 1'b0;
      tbl[k] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      flows[i] = random_record();
      if (i % 2 == 1) begin
        flows[i] = flows[i - 1];
        flows[i].router_addr_hi = {$urandom, $urandom};
      end
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    clock_us = '0;
    // time restarts at zero; entries already stored keep their expiry
    write_lifetime(40'd1);
    req.payload.now_us <= '0;
    test_random(350, 40'd1, 48'd3);
    test_random(350, 40'd60, 48'd4);
    test_backpressure();
    test_random(250, 40'd1000, 48'd30);
    gaps_on = 1'b0;
    test_random(150, 40'd25, 48'd2);
    drain_results();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/rrdf_pkg.sv
hw/rtl/rrdf_if.sv
hw/rtl/rrdf_mem.sv
hw/rtl/route_request_duplicate_filter_top.sv
tb/sv/tb.sv
